### rtl/srgba_pkg.sv
package srgba_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;

  localparam int MAX_OBJ_DIM = 240;
  localparam int SCREEN_W    = 320;
  localparam int SCREEN_H    = 240;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_SRC_PITCH  = 3'd2,
    REG_RECT_LEFT  = 3'd3,
    REG_RECT_TOP   = 3'd4,
    REG_RECT_W     = 3'd5,
    REG_RECT_H     = 3'd6
  } reg_idx_t;

  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_COMPOSITE = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [15:0] ROUND_HALF  = 16'd127;

  typedef struct packed {
    logic [7:0] rem;
    logic       q;
  } div_step_t;

  // one restoring division step
  function automatic div_step_t div_step(logic [7:0] rem, logic nb, logic [7:0] den);
    logic [8:0] t;
    div_step_t  r;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      r.q   = 1'b1;
      r.rem = 8'(t - {1'b0, den});
    end else begin
      r.q   = 1'b0;
      r.rem = t[7:0];
    end
    return r;
  endfunction

  // exact s / 255 for s below 65280
  function automatic logic [7:0] div255(logic [15:0] s);
    logic [16:0] t;
    t = {1'b0, s} + 17'(s[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [15:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [7:0] expand5(logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [7:0] expand6(logic [5:0] x);
    return {x, x[5:4]};
  endfunction

endpackage

### rtl/srgba_div.sv
module srgba_div
  import srgba_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] num,
  input  logic [7:0]  den,
  output logic [7:0]  quo
);

  logic [7:0] rem   [4];
  logic [7:0] qpart [4];
  logic [7:0] low   [3];

  for (genvar k = 0; k < 4; k++) begin : g_stage
    logic [7:0] in_rem;
    logic [7:0] in_low;
    logic [7:0] in_q;
    div_step_t  s1;
    div_step_t  s2;

    if (k == 0) begin : g_first
      assign in_rem = num[15:8];
      assign in_low = num[7:0];
      assign in_q   = 8'd0;
    end else begin : g_rest
      assign in_rem = rem[k-1];
      assign in_low = low[k-1];
      assign in_q   = qpart[k-1];
    end

    always_comb begin
      s1 = div_step(in_rem, in_low[7], den);
      s2 = div_step(s1.rem, in_low[6], den);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= s2.rem;
        qpart[k] <= {in_q[5:0], s1.q, s2.q};
      end
    end

    if (k < 3) begin : g_low
      always_ff @(posedge clk) begin
        if (en) begin
          low[k] <= {in_low[5:0], 2'b00};
        end
      end
    end
  end

  assign quo = qpart[3];

endmodule

### rtl/scaled_rgba_over_rgb565_compositor_core.sv
// scaled rgba over rgb565 compositor
// input channel: in_valid / in_stall with cmd, texel_index, texel_rgba,
//   off_x, off_y, background_pixel. load items (cmd 0) write one texel
//   into the object store if texel_index is in range and give no result; composite items (cmd 1)
//   give one result on the output channel.
// output channel: out_valid / out_stall with out_pixel, write_enable,
//   fb_address, config_error.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high, write only while the block is idle.
// throughput: one item per cycle while the output does not stall. a composite
//   result passes through the product, four radix-4 divider stages for the
//   scaling, index multiply, store read, blend multiply and output register.
// reset clears the pipeline valid bits and all config registers; the
//   object store is not cleared and reads garbage until written.
// when the receiver stalls a waiting result, the whole pipeline holds
//   and in_stall is raised; nothing is lost or repeated.
module scaled_rgba_over_rgb565_compositor_core
  import srgba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [15:0]         texel_index,
  input  logic [31:0]         texel_rgba,
  input  logic [7:0]          off_x,
  input  logic [7:0]          off_y,
  input  logic [15:0]         background_pixel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_pixel,
  output logic                write_enable,
  output logic [16:0]         fb_address,
  output logic                config_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int Depth = MAX_OBJ_DIM * MAX_OBJ_DIM;
  localparam int AW    = $clog2(Depth);

  typedef struct packed {
    logic        cmd;
    logic [15:0] tidx;
    logic [31:0] trgba;
    logic [15:0] bg;
    logic [16:0] addr;
    logic        skip;
    logic        bad;
  } item_t;

  logic [7:0] src_width, src_height, src_pitch, rect_top, rect_w, rect_h;
  logic [8:0] rect_left;
  logic       cfg_bad;
  logic       adv;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= '0;
      src_height <= '0;
      src_pitch  <= '0;
      rect_left  <= '0;
      rect_top   <= '0;
      rect_w     <= '0;
      rect_h     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[7:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[7:0];
        REG_SRC_PITCH:  src_pitch  <= cfg_data[7:0];
        REG_RECT_LEFT:  rect_left  <= cfg_data;
        REG_RECT_TOP:   rect_top   <= cfg_data[7:0];
        REG_RECT_W:     rect_w     <= cfg_data[7:0];
        REG_RECT_H:     rect_h     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_bad = (src_width == 8'd0) || (src_height == 8'd0) ||
              (32'(src_width) > MAX_OBJ_DIM) || (32'(src_height) > MAX_OBJ_DIM) ||
              (src_pitch < src_width) || (rect_w == 8'd0) || (rect_h == 8'd0) ||
              (32'(rect_w) > MAX_OBJ_DIM) || (32'(rect_h) > MAX_OBJ_DIM) ||
              (32'(rect_left) + 32'(rect_w) > SCREEN_W) ||
              (32'(rect_top) + 32'(rect_h) > SCREEN_H);
  end

  // stage 0: scaling products and screen position
  item_t       it0;
  logic        v0;
  logic [15:0] prodx, prody;
  logic [8:0]  row0;
  logic [9:0]  col0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it0.cmd   <= cmd;
      it0.tidx  <= texel_index;
      it0.trgba <= texel_rgba;
      it0.bg    <= background_pixel;
      it0.addr  <= '0;
      it0.skip  <= (off_x >= rect_w) || (off_y >= rect_h);
      it0.bad   <= cfg_bad;
      prodx     <= 16'(off_x) * 16'(src_width);
      prody     <= 16'(off_y) * 16'(src_height);
      row0      <= 9'(rect_top) + 9'(off_y);
      col0      <= 10'(rect_left) + 10'(off_x);
    end
  end

  // divider stages
  item_t      sd   [4];
  logic       sd_v [4];
  logic [7:0] sx, sy;
  item_t      it0a;

  always_comb begin
    it0a      = it0;
    it0a.addr = 17'(32'(row0) * SCREEN_W + 32'(col0));
  end

  srgba_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (prodx),
    .den (rect_w),
    .quo (sx)
  );

  srgba_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (prody),
    .den (rect_h),
    .quo (sy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) sd_v[i] <= 1'b0;
    end else if (adv) begin
      sd_v[0] <= v0;
      for (int i = 1; i < 4; i++) sd_v[i] <= sd_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= it0a;
      for (int i = 1; i < 4; i++) sd[i] <= sd[i-1];
    end
  end

  // stage 5: store index
  item_t       it5;
  logic        v5;
  logic [16:0] idx5;

  // stage 6: store access
  item_t       it6;
  logic        v6;
  logic        inrange6;
  logic [31:0] rdata;
  logic [31:0] store [Depth];

  // stage 7: blend products
  item_t       it7;
  logic        v7;
  logic [7:0]  a7;
  logic [23:0] fg7;
  logic [15:0] sr7, sg7, sb7;

  logic [31:0] texel6;
  logic [7:0]  a6, br6, bgc6, bb6, fr6, fgc6, fb6;

  always_comb begin
    texel6 = inrange6 ? rdata : 32'd0;
    a6     = texel6[31:24];
    fr6    = texel6[7:0];
    fgc6   = texel6[15:8];
    fb6    = texel6[23:16];
    br6    = expand5(it6.bg[15:11]);
    bgc6   = expand6(it6.bg[10:5]);
    bb6    = expand5(it6.bg[4:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v5 <= sd_v[3];
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it5  <= sd[3];
      idx5 <= 17'(sy) * 17'(src_pitch) + 17'(sx);
      it6  <= it5;
      it7  <= it6;
      a7   <= a6;
      fg7  <= texel6[23:0];
      sr7  <= 16'(16'(fr6) * 16'(a6) + 16'(br6) * 16'(ALPHA_OPAQUE - a6) + ROUND_HALF);
      sg7  <= 16'(16'(fgc6) * 16'(a6) + 16'(bgc6) * 16'(ALPHA_OPAQUE - a6) + ROUND_HALF);
      sb7  <= 16'(16'(fb6) * 16'(a6) + 16'(bb6) * 16'(ALPHA_OPAQUE - a6) + ROUND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v5) begin
      if (it5.cmd == CMD_LOAD) begin
        if (32'(it5.tidx) < Depth) store[AW'(it5.tidx)] <= it5.trgba;
      end else begin
        rdata    <= store[AW'(idx5)];
        inrange6 <= (32'(idx5) < Depth);
      end
    end
  end

  // output stage
  logic [15:0] pix_next;
  logic        we_next;
  logic [16:0] addr_next;
  logic        err_next;

  always_comb begin
    pix_next  = it7.bg;
    we_next   = 1'b0;
    addr_next = '0;
    err_next  = 1'b0;
    if (it7.bad) begin
      err_next = 1'b1;
    end else if (!it7.skip) begin
      addr_next = it7.addr;
      if (a7 == ALPHA_OPAQUE) begin
        pix_next = pack565(fg7[7:0], fg7[15:8], fg7[23:16]);
        we_next  = 1'b1;
      end else if (a7 != ALPHA_CLEAR) begin
        pix_next = pack565(div255(sr7), div255(sg7), div255(sb7));
        we_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v7 && (it7.cmd == CMD_COMPOSITE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel    <= pix_next;
      write_enable <= we_next;
      fb_address   <= addr_next;
      config_error <= err_next;
    end
  end

`ifndef SYNTH
  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && config_error |-> !write_enable && fb_address == 17'd0)
    else $error("config error result carries a write");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(v7) && $stable(it7))
    else $error("pipeline moved during stall");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    adv && v7 && it7.cmd == CMD_LOAD |=> !out_valid)
    else $error("load item produced a result");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

class pixel_scoreboard;
  logic [31:0] obj_mem [int];
  logic [7:0]  s_w, s_h, s_p, r_top, r_w, r_h;
  logic [8:0]  r_left;
  logic [15:0] exp_pix [$];
  logic        exp_we [$];
  logic [16:0] exp_addr [$];
  logic        exp_err [$];
  int          errors;
  int          n_results;

  function new();
    errors = 0;
    n_results = 0;
    s_w = 0; s_h = 0; s_p = 0; r_left = 0; r_top = 0; r_w = 0; r_h = 0;
  endfunction

  function void set_reg(srgba_pkg::reg_idx_t idx, logic [8:0] v);
    case (idx)
      srgba_pkg::REG_SRC_WIDTH:  s_w = v[7:0];
      srgba_pkg::REG_SRC_HEIGHT: s_h = v[7:0];
      srgba_pkg::REG_SRC_PITCH:  s_p = v[7:0];
      srgba_pkg::REG_RECT_LEFT:  r_left = v;
      srgba_pkg::REG_RECT_TOP:   r_top = v[7:0];
      srgba_pkg::REG_RECT_W:     r_w = v[7:0];
      srgba_pkg::REG_RECT_H:     r_h = v[7:0];
      default: ;
    endcase
  endfunction

  function bit bad_cfg();
    if (s_w == 0 || s_h == 0 || s_w > 240 || s_h > 240) return 1;
    if (s_p < s_w) return 1;
    if (r_w == 0 || r_h == 0 || r_w > 240 || r_h > 240) return 1;
    if (int'(r_left) + int'(r_w) > 320) return 1;
    if (int'(r_top) + int'(r_h) > 240) return 1;
    return 0;
  endfunction

  function int blend(int f, int b, int a);
    return (f * a + b * (255 - a) + 127) / 255;
  endfunction

  function void note_item(logic c, logic [15:0] tidx, logic [31:0] rgba,
                          logic [7:0] ox, logic [7:0] oy, logic [15:0] bg);
    int sx, sy, ix, a, br, bgn, bb, r, g, b;
    logic [31:0] t;
    logic [15:0] pix;
    logic we;
    logic [16:0] addr;
    if (c == srgba_pkg::CMD_LOAD) begin
      if (tidx < 57600) obj_mem[tidx] = rgba;
      return;
    end
    pix = bg; we = 0; addr = 0;
    if (bad_cfg()) begin
      exp_pix.push_back(pix); exp_we.push_back(0);
      exp_addr.push_back(0); exp_err.push_back(1);
      return;
    end
    if (ox < r_w && oy < r_h) begin
      addr = 17'((int'(r_top) + oy) * 320 + int'(r_left) + ox);
      sx = int'(ox) * s_w / r_w;
      sy = int'(oy) * s_h / r_h;
      ix = sy * s_p + sx;
      t = (ix < 57600 && obj_mem.exists(ix)) ? obj_mem[ix] : 32'd0;
      a = t[31:24];
      if (a != 0) begin
        we = 1;
        if (a == 255) begin
          r = t[7:0]; g = t[15:8]; b = t[23:16];
        end else begin
          br = {bg[15:11], bg[15:13]};
          bgn = {bg[10:5], bg[10:9]};
          bb = {bg[4:0], bg[4:2]};
          r = blend(t[7:0], br, a);
          g = blend(t[15:8], bgn, a);
          b = blend(t[23:16], bb, a);
        end
        pix = {r[7:3], g[7:2], b[7:3]};
      end
    end
    exp_pix.push_back(pix); exp_we.push_back(we);
    exp_addr.push_back(addr); exp_err.push_back(0);
  endfunction

  function void check_result(logic [15:0] pix, logic we, logic [16:0] addr, logic err);
    n_results++;
    if (exp_pix.size() == 0) begin
      $display("%0t: unexpected result pix=%h", $time, pix);
      errors++;
      return;
    end
    if (exp_pix[0] !== pix) begin
      $display("%0t: out_pixel expected %h actual %h", $time, exp_pix[0], pix);
      errors++;
    end
    if (exp_we[0] !== we) begin
      $display("%0t: write_enable expected %b actual %b", $time, exp_we[0], we);
      errors++;
    end
    if (exp_addr[0] !== addr) begin
      $display("%0t: fb_address expected %h actual %h", $time, exp_addr[0], addr);
      errors++;
    end
    if (exp_err[0] !== err) begin
      $display("%0t: config_error expected %b actual %b", $time, exp_err[0], err);
      errors++;
    end
    void'(exp_pix.pop_front()); void'(exp_we.pop_front());
    void'(exp_addr.pop_front()); void'(exp_err.pop_front());
  endfunction

  function int pending();
    return exp_pix.size();
  endfunction
endclass

module testbench;
  import srgba_pkg::*;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic cmd = 0;
  logic [15:0] texel_index = 0;
  logic [31:0] texel_rgba = 0;
  logic [7:0] off_x = 0, off_y = 0;
  logic [15:0] background_pixel = 0;
  logic out_valid, out_stall = 0;
  logic [15:0] out_pixel;
  logic write_enable, config_error;
  logic [16:0] fb_address;
  logic cfg_valid = 0, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = 0;
  logic [CfgDataW-1:0] cfg_data = 0;

  bit quiet = 0;
  int n_items = 0;
  pixel_scoreboard sb;

  scaled_rgba_over_rgb565_compositor_core dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(out_pixel, write_enable, fb_address, config_error);
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 37);
    end
  end

  task automatic idle_gap();
    while (!quiet && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic send(logic c, logic [15:0] ti, logic [31:0] rgba,
                      logic [7:0] ox, logic [7:0] oy, logic [15:0] bg);
    idle_gap();
    in_valid <= 1; cmd <= c; texel_index <= ti; texel_rgba <= rgba;
    off_x <= ox; off_y <= oy; background_pixel <= bg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(c, ti, rgba, ox, oy, bg);
    n_items++;
  endtask

  task automatic drain();
    int k;
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    for (k = 0; k < 12; k++) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [8:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic setup(int sw, int sh, int sp, int rl, int rt, int rw, int rh);
    drain();
    write_reg(REG_SRC_WIDTH, 9'(sw));
    write_reg(REG_SRC_HEIGHT, 9'(sh));
    write_reg(REG_SRC_PITCH, 9'(sp));
    write_reg(REG_RECT_LEFT, 9'(rl));
    write_reg(REG_RECT_TOP, 9'(rt));
    write_reg(REG_RECT_W, 9'(rw));
    write_reg(REG_RECT_H, 9'(rh));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // fill the whole source image so every scaled read hits a written texel
  task automatic load_image(int sw, int sh, int sp);
    int x, y;
    logic [31:0] t;
    for (y = 0; y < sh; y++)
      for (x = 0; x < sw; x++) begin
        t = $urandom;
        case ($urandom_range(3))
          0: t[31:24] = ALPHA_CLEAR;
          1: t[31:24] = ALPHA_OPAQUE;
          default: ;
        endcase
        send(CMD_LOAD, 16'(y * sp + x), t, 8'($urandom), 8'($urandom), 16'($urandom));
      end
  endtask

  task automatic random_pixels(int n, int rw, int rh);
    int k;
    for (k = 0; k < n; k++)
      if ($urandom_range(9) == 0)
        send(CMD_COMPOSITE, 16'($urandom), 32'($urandom), 8'($urandom), 8'($urandom),
             16'($urandom));
      else
        send(CMD_COMPOSITE, 16'($urandom), 32'($urandom), 8'($urandom_range(rw - 1)),
             8'($urandom_range(rh - 1)), 16'($urandom));
  endtask

  initial begin
    int ph, sw, sh, sp, rw, rh, rl, rt;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset config is invalid
    send(CMD_COMPOSITE, 0, 0, 0, 0, 16'hffff);
    // bad configs: oversize, pitch below width, rect off screen
    setup(241, 4, 241, 0, 0, 4, 4);
    send(CMD_COMPOSITE, 0, 0, 1, 1, 16'h1234);
    setup(4, 4, 3, 0, 0, 4, 4);
    send(CMD_COMPOSITE, 0, 0, 1, 1, 16'h1234);
    setup(4, 4, 4, 319, 0, 2, 4);
    send(CMD_COMPOSITE, 0, 0, 0, 0, 16'h1234);
    setup(4, 4, 4, 0, 239, 4, 2);
    send(CMD_COMPOSITE, 0, 0, 0, 0, 16'h1234);

    // 2x2 image over 4x4 rect, edge alphas and out of range offsets
    setup(2, 2, 240, 80, 100, 4, 4);
    send(CMD_LOAD, 0, 32'h00ffffff, 0, 0, 0);
    send(CMD_LOAD, 1, 32'hff123456, 0, 0, 0);
    send(CMD_LOAD, 240, 32'h01ffffff, 0, 0, 0);
    send(CMD_LOAD, 241, 32'hfe000000, 0, 0, 0);
    send(CMD_LOAD, 16'hffff, 32'hffffffff, 0, 0, 0);
    send(CMD_COMPOSITE, 0, 0, 0, 0, 16'hffff);
    send(CMD_COMPOSITE, 0, 0, 3, 0, 16'h0000);
    send(CMD_COMPOSITE, 0, 0, 0, 3, 16'h0000);
    send(CMD_COMPOSITE, 0, 0, 3, 3, 16'hffff);
    send(CMD_COMPOSITE, 0, 0, 4, 0, 16'hffff);
    send(CMD_COMPOSITE, 0, 0, 0, 255, 16'hffff);

    // large pitch reads past the store; a tall rect scaled from a 2x2 image
    setup(240, 240, 250, 80, 0, 240, 240);
    send(CMD_COMPOSITE, 0, 0, 239, 239, 16'h5555);
    setup(2, 2, 240, 80, 0, 2, 240);
    send(CMD_COMPOSITE, 0, 0, 1, 239, 16'h5555);

    for (ph = 0; ph < 8; ph++) begin
      sw = $urandom_range(1, 8); sh = $urandom_range(1, 8);
      sp = $urandom_range(sw, 12);
      rw = (ph == 3) ? 240 : $urandom_range(1, 60);
      rh = (ph == 3) ? 240 : $urandom_range(1, 60);
      rl = (ph == 3) ? 80 : $urandom_range(0, 320 - rw);
      rt = (ph == 3) ? 0 : $urandom_range(0, 240 - rh);
      quiet = (ph == 5);
      setup(sw, sh, sp, rl, rt, rw, rh);
      load_image(sw, sh, sp);
      random_pixels(40, rw, rh);
      if (ph == 2) begin
        drain();
        random_pixels(10, rw, rh);
      end
    end
    quiet = 0;

    drain();
    $display("%0d items sent, %0d results checked over %0d configurations written",
             n_items, sb.n_results, 15);
    $display("covered load, composite, alpha edges, bad configs and edge offsets");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
